// ----- design/crs_pkg.sv -----
package crs_pkg;

	// configuration register indices
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MIN    = 2'd2;

	localparam int unsigned WIDTH_CFG_W = 7;
	localparam int unsigned THRESH_W    = 4;
	localparam int unsigned COUNT_W     = 4;

	localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET   = 7'd64;
	localparam logic [THRESH_W-1:0]    SURVIVE_RESET = 4'd3;
	localparam logic [THRESH_W-1:0]    BIRTH_RESET   = 4'd4;

	// thresholds shared by every lane
	typedef struct packed {
		logic [THRESH_W-1:0] survive_min;
		logic [THRESH_W-1:0] birth_min;
	} crs_rule_t;

endpackage

// ----- design/crs_lane.sv -----
module crs_lane import crs_pkg::*; (
	input  logic [2:0] above,
	input  logic [2:0] here,
	input  logic [2:0] below,
	input  crs_rule_t  rule,
	output logic       cell_out
);

	logic [COUNT_W-1:0] n;

	always_comb begin
		n = COUNT_W'(above[0]) + COUNT_W'(above[1]) + COUNT_W'(above[2])
		  + COUNT_W'(here[0])  + COUNT_W'(here[2])
		  + COUNT_W'(below[0]) + COUNT_W'(below[1]) + COUNT_W'(below[2]);
		if (here[1]) begin
			cell_out = (n >= rule.survive_min);
		end else begin
			cell_out = (n >= rule.birth_min);
		end
	end

endmodule

// ----- design/crs_row.sv -----
module crs_row import crs_pkg::*; #(
	parameter int unsigned ROW_BITS = 64
) (
	input  logic [ROW_BITS-1:0]    above,
	input  logic [ROW_BITS-1:0]    here,
	input  logic [ROW_BITS-1:0]    below,
	input  logic [WIDTH_CFG_W-1:0] width_in_use,
	input  crs_rule_t              rule,
	output logic [ROW_BITS-1:0]    row_out
);

	logic [ROW_BITS-1:0] vmask;
	logic [ROW_BITS-1:0] lane_bit;
	logic [ROW_BITS+1:0] ext_a, ext_h, ext_b;

	// columns past the width in use read as wall
	for (genvar c = 0; c < ROW_BITS; c++) begin : g_mask
		assign vmask[c] = (WIDTH_CFG_W'(c) < width_in_use);
	end

	// one wall column either side of the row
	assign ext_a = {1'b1, above | ~vmask, 1'b1};
	assign ext_h = {1'b1, here  | ~vmask, 1'b1};
	assign ext_b = {1'b1, below | ~vmask, 1'b1};

	for (genvar c = 0; c < ROW_BITS; c++) begin : g_lane
		crs_lane u_lane (
			.above    (ext_a[c+2:c]),
			.here     (ext_h[c+2:c]),
			.below    (ext_b[c+2:c]),
			.rule     (rule),
			.cell_out (lane_bit[c])
		);
	end

	// merge: assemble the row, dead columns forced open
	assign row_out = lane_bit & vmask;

endmodule

// ----- design/crs_out_fifo.sv -----
module crs_out_fifo #(
	parameter int unsigned DATA_W = 65
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic [DATA_W-1:0] data0,
	input  logic              push1,
	input  logic [DATA_W-1:0] data1,
	output logic              room2,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CNT_W-1:0]  cnt_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign room2     = (cnt_q <= CNT_W'(DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= data0;
		end
		if (push1) begin
			mem_q[wr_ptr_p1] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push0) + PTR_W'(push1);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
		end
	end

endmodule

// ----- design/cave_automaton_row_step_core.sv -----
// Cave-smoothing automaton, one generation, one grid row per transfer.
// Output: a row's update is pushed into the result queue when the row
// below it is taken; the final row pushes both pending rows at once.
// Throughput: one row per cycle while the queue drains one result per
// cycle and has room for two; a final row adds one extra result.
// Reset: asynchronous, active low; thresholds and width return to defaults.
module cave_automaton_row_step_core import crs_pkg::*; #(
	parameter int unsigned ROW_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WIDTH_CFG_W-1:0] cfg_data,
	// row input
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ROW_BITS-1:0]    row_cells,
	input  logic                   final_row,
	// updated rows
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ROW_BITS-1:0]    new_row_cells,
	output logic                   frame_end
);

	localparam int unsigned RES_W = ROW_BITS + 1;

	logic [WIDTH_CFG_W-1:0] width_q;
	crs_rule_t              rule_q;

	logic [ROW_BITS-1:0] upper_q, middle_q;
	logic [1:0]          seen_q;

	logic                accept;
	logic                fresh;      // no rows held: start of grid
	logic [ROW_BITS-1:0] above_a, above_b;
	logic [ROW_BITS-1:0] res_a, res_b;
	logic                push0, push1, room2;
	logic [RES_W-1:0]    data0, data1, head;

	// registers are always writable; host writes only while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q            <= WIDTH_RESET;
			rule_q.survive_min <= SURVIVE_RESET;
			rule_q.birth_min   <= BIRTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH_IN_USE: width_q            <= cfg_data;
				CFG_SURVIVE_MIN:  rule_q.survive_min <= cfg_data[THRESH_W-1:0];
				CFG_BIRTH_MIN:    rule_q.birth_min   <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// take a row only if the queue can absorb two results
	assign in_ready = room2;
	assign accept   = in_valid && in_ready;
	assign fresh    = (seen_q == 2'd0);

	// array A: the pending middle row, with the new row below it.
	// With only one row held the row above is the wall border.
	assign above_a = (seen_q == 2'd1) ? '1 : upper_q;

	crs_row #(.ROW_BITS(ROW_BITS)) u_row_a (
		.above        (above_a),
		.here         (middle_q),
		.below        (row_cells),
		.width_in_use (width_q),
		.rule         (rule_q),
		.row_out      (res_a)
	);

	// array B: the incoming row with walls below; only used on a final row
	assign above_b = fresh ? '1 : middle_q;

	crs_row #(.ROW_BITS(ROW_BITS)) u_row_b (
		.above        (above_b),
		.here         (row_cells),
		.below        ('1),
		.width_in_use (width_q),
		.rule         (rule_q),
		.row_out      (res_b)
	);

	// single-row grid: B alone, flagged as frame end
	assign push0 = accept && (!fresh || final_row);
	assign push1 = accept && !fresh && final_row;
	assign data0 = fresh ? {res_b, 1'b1} : {res_a, 1'b0};
	assign data1 = {res_b, 1'b1};

	crs_out_fifo #(.DATA_W(RES_W)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.data0     (data0),
		.push1     (push1),
		.data1     (data1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (head)
	);

	assign new_row_cells = head[RES_W-1:1];
	assign frame_end     = head[0];

	// row history; raw rows kept, masking applied when used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= '0;
			middle_q <= '0;
			seen_q   <= 2'd0;
		end else if (accept) begin
			if (final_row) begin
				upper_q  <= '0;
				middle_q <= '0;
				seen_q   <= 2'd0;
			end else if (fresh) begin
				middle_q <= row_cells;
				seen_q   <= 2'd1;
			end else begin
				upper_q  <= middle_q;
				middle_q <= row_cells;
				seen_q   <= 2'd2;
			end
		end
	end

endmodule
